// File: hdl/ellipsoid_voxel_partial_volume_assert.svh
// Assertion macros for the checker file of the voxel classifier.
`ifndef ELLIPSOID_VOXEL_PARTIAL_VOLUME_ASSERT_SVH
`define ELLIPSOID_VOXEL_PARTIAL_VOLUME_ASSERT_SVH
// same-cycle implication, clocked on clk_i, off during reset
`define EVPV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, clocked on clk_i, off during reset
`define EVPV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hdl/evpv_pkg.sv
// Shared types, constants and codes of the ellipsoid voxel classifier.
package evpv_pkg;

  localparam int unsigned SUBSTEPS_DEF   = 9;
  localparam int unsigned INDEX_BITS_DEF = 10;

  localparam int unsigned CENTRE_W = 24;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned SAMPLES_W = 10;
  localparam int unsigned OFF_W = 14;    // signed Q.12 offset, covers +-1 voxel
  localparam int unsigned TERM_W = 30;   // clamped per-axis term
  localparam int unsigned CNT_W = 13;    // up to 16^3 samples
  localparam int unsigned GIDX_W = 4;    // grid index 0..SUBSTEPS
  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned ONE_Q12 = 4096;
  localparam int unsigned HALF_Q12 = 2048;

  localparam logic [31:0] INSIDE_LIMIT = 32'd268435483;
  localparam logic [TERM_W-1:0] TERM_BIG = TERM_W'(30'h2000_0000);
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 32'h1000_0000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTRE_X = 3'd0,
    CFG_CENTRE_Y = 3'd1,
    CFG_CENTRE_Z = 3'd2,
    CFG_WEIGHT_X = 3'd3,
    CFG_WEIGHT_Y = 3'd4,
    CFG_WEIGHT_Z = 3'd5,
    CFG_PARTIAL  = 3'd6
  } cfg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_BG      = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_PARTIAL = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEIGH,
    ST_NDRAIN,
    ST_GRID,
    ST_GDRAIN,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic                    load_vox;
    logic                    clear;
    logic                    issue;
    logic                    tag;      // point is the voxel centre
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
    logic signed [OFF_W-1:0] off_z;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             busy;
    logic             centre_in;
    logic             partial;
    logic [CNT_W-1:0] count;
  } dp_status_t;

endpackage

// File: hdl/evpv_axis.sv
// One axis lane: clamped floor(d^2 * weight / 2^24) over five register stages.
module evpv_axis
  import evpv_pkg::*;
#(
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic signed [CENTRE_W-1:0]     centre_i,
  input  logic        [WEIGHT_W-1:0]     weight_i,
  input  logic signed [INDEX_BITS+13:0]  pos_i,
  output logic        [TERM_W-1:0]       term_o
);
  localparam int unsigned PW  = INDEX_BITS + 14;
  localparam int unsigned SW  = ((PW > CENTRE_W) ? PW : CENTRE_W) + 1;
  localparam int unsigned DW  = SW - 1;
  localparam int unsigned SQW = 2 * DW;
  localparam int unsigned SHW = SQW - 32;
  localparam int unsigned HPW = SHW + WEIGHT_W;

  logic signed [SW-1:0]  diff;
  logic [DW-1:0]         ad_q;
  logic [SQW-1:0]        sq_q;
  logic [63:0]           plo_q;
  logic [SHW-1:0]        sqhi_q;
  logic [HPW-1:0]        phi_q;
  logic [39:0]           losh_q;
  logic [40:0]           tsum;
  logic                  big;
  logic [TERM_W-1:0]     term_q;

  assign diff = SW'(centre_i) - SW'(pos_i);

  // magnitude, square, then the two weight products
  always_ff @(posedge clk_i) begin
    ad_q   <= diff[SW-1] ? DW'(-diff) : DW'(diff);
    sq_q   <= SQW'(ad_q) * SQW'(ad_q);
    plo_q  <= 64'(sq_q[31:0]) * 64'(weight_i);
    sqhi_q <= sq_q[SQW-1:32];
    phi_q  <= HPW'(sqhi_q) * HPW'(weight_i);
    losh_q <= plo_q[63:24];
    term_q <= big ? TERM_BIG : tsum[TERM_W-1:0];
  end

  // anything at or above 2^29 is far outside, clamp it
  assign tsum = {12'd0, phi_q[20:0], 8'd0} + {1'b0, losh_q};
  assign big  = (|phi_q[HPW-1:21]) || (tsum >= 41'h2000_0000);

  assign term_o = term_q;
endmodule

// File: hdl/evpv_datapath.sv
// Datapath: config registers, point pipeline of three axis lanes, inside counter.
module evpv_datapath
  import evpv_pkg::*;
#(
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [INDEX_BITS-1:0] voxel_x_i,
  input  logic [INDEX_BITS-1:0] voxel_y_i,
  input  logic [INDEX_BITS-1:0] voxel_z_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o
);
  localparam int unsigned PW = INDEX_BITS + 14;
  localparam int unsigned LAT = 7;

  logic signed [CENTRE_W-1:0] cx_q, cy_q, cz_q;
  logic [WEIGHT_W-1:0]        wx_q, wy_q, wz_q;
  logic                       partial_q;
  logic [INDEX_BITS-1:0]      vx_q, vy_q, vz_q;
  logic signed [PW-1:0]       px_q, py_q, pz_q;
  logic [TERM_W-1:0]          tx, ty, tz;
  logic [LAT-1:0]             vld_q;
  logic [LAT-1:0]             tag_q;
  logic                       inside_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       cin_q;
  logic [31:0]                tsum;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; cz_q <= '0;
      wx_q <= WEIGHT_ONE; wy_q <= WEIGHT_ONE; wz_q <= WEIGHT_ONE;
      partial_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CENTRE_X: cx_q <= cfg_data_i[CENTRE_W-1:0];
        CFG_CENTRE_Y: cy_q <= cfg_data_i[CENTRE_W-1:0];
        CFG_CENTRE_Z: cz_q <= cfg_data_i[CENTRE_W-1:0];
        CFG_WEIGHT_X: wx_q <= cfg_data_i;
        CFG_WEIGHT_Y: wy_q <= cfg_data_i;
        CFG_WEIGHT_Z: wz_q <= cfg_data_i;
        CFG_PARTIAL:  partial_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // voxel index and sample positions
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_vox) begin
      vx_q <= voxel_x_i;
      vy_q <= voxel_y_i;
      vz_q <= voxel_z_i;
    end
    px_q <= PW'({2'b00, vx_q, 12'd0}) + PW'(cmd_i.off_x);
    py_q <= PW'({2'b00, vy_q, 12'd0}) + PW'(cmd_i.off_y);
    pz_q <= PW'({2'b00, vz_q, 12'd0}) + PW'(cmd_i.off_z);
    inside_q <= (tsum <= INSIDE_LIMIT);
  end

  evpv_axis #(.INDEX_BITS(INDEX_BITS)) u_ax_x (
    .clk_i(clk_i), .centre_i(cx_q), .weight_i(wx_q), .pos_i(px_q), .term_o(tx));
  evpv_axis #(.INDEX_BITS(INDEX_BITS)) u_ax_y (
    .clk_i(clk_i), .centre_i(cy_q), .weight_i(wy_q), .pos_i(py_q), .term_o(ty));
  evpv_axis #(.INDEX_BITS(INDEX_BITS)) u_ax_z (
    .clk_i(clk_i), .centre_i(cz_q), .weight_i(wz_q), .pos_i(pz_q), .term_o(tz));

  assign tsum = 32'(tx) + 32'(ty) + 32'(tz);

  // valid and centre tag follow the points down the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      tag_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], cmd_i.issue};
      tag_q <= {tag_q[LAT-2:0], cmd_i.issue & cmd_i.tag};
    end
  end

  // count of points found inside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cin_q <= 1'b0;
    end else if (cmd_i.clear) begin
      cnt_q <= '0;
      cin_q <= 1'b0;
    end else if (vld_q[LAT-1] && inside_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (tag_q[LAT-1]) cin_q <= 1'b1;
    end
  end

  assign status_o.busy      = |vld_q;
  assign status_o.centre_in = cin_q;
  assign status_o.partial   = partial_q;
  assign status_o.count     = cnt_q;
endmodule

// File: hdl/evpv_ctrl.sv
// Controller: sequences the seven point tests and the sample grid, holds the result.
module evpv_ctrl
  import evpv_pkg::*;
#(
  parameter int unsigned SUBSTEPS = SUBSTEPS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [KIND_W-1:0]    voxel_kind_o,
  output logic [SAMPLES_W-1:0] inside_samples_o,
  input  dp_status_t           status_i,
  output dp_cmd_t              cmd_o
);
  localparam int unsigned STEP_Q = ONE_Q12 / SUBSTEPS;
  localparam int unsigned STEP_R = ONE_Q12 % SUBSTEPS;
  localparam int unsigned REM0   = SUBSTEPS / 2;

  typedef struct packed {
    logic signed [OFF_W-1:0] off;
    logic [GIDX_W-1:0]       rem;
  } grid_t;

  // next grid offset: -0.5 + a/SUBSTEPS, rounded, kept as quotient and remainder
  function automatic grid_t grid_step(grid_t g);
    logic [GIDX_W:0] r;
    grid_t n;
    r = {1'b0, g.rem} + (GIDX_W + 1)'(STEP_R);
    if (r >= (GIDX_W + 1)'(SUBSTEPS)) begin
      n.rem = GIDX_W'(r - (GIDX_W + 1)'(SUBSTEPS));
      n.off = g.off + OFF_W'(STEP_Q) + OFF_W'(1);
    end else begin
      n.rem = r[GIDX_W-1:0];
      n.off = g.off + OFF_W'(STEP_Q);
    end
    return n;
  endfunction

  localparam grid_t GRID0 = '{off: -OFF_W'(HALF_Q12), rem: GIDX_W'(REM0)};

  state_e state_q, state_d;
  logic [2:0]        pt_q;
  logic [GIDX_W-1:0] ia_q, ib_q, ie_q;
  grid_t             ga_q, gb_q, ge_q;
  kind_e             res_q;
  logic              out_valid_q;
  logic [KIND_W-1:0] kind_q;
  logic [SAMPLES_W-1:0] samp_q;
  logic              in_xfer, out_free, grid_last, ndone;
  kind_e             decide;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign grid_last = (ia_q == GIDX_W'(SUBSTEPS)) && (ib_q == GIDX_W'(SUBSTEPS))
                  && (ie_q == GIDX_W'(SUBSTEPS));
  assign ndone     = (pt_q == 3'd6);

  // outcome of the seven point tests
  always_comb begin
    if (status_i.count == CNT_W'(7))        decide = KIND_FULL;
    else if (status_i.count == '0)          decide = KIND_BG;
    else if (status_i.partial)              decide = KIND_PARTIAL;
    else if (status_i.centre_in)            decide = KIND_FULL;
    else                                    decide = KIND_BG;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_xfer) state_d = ST_NEIGH;
      ST_NEIGH:  if (ndone) state_d = ST_NDRAIN;
      ST_NDRAIN: if (!status_i.busy) state_d = (decide == KIND_PARTIAL) ? ST_GRID : ST_DONE;
      ST_GRID:   if (grid_last) state_d = ST_GDRAIN;
      ST_GDRAIN: if (!status_i.busy) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_vox = in_xfer;
        cmd_o.clear    = in_xfer;
      end
      ST_NEIGH: begin
        cmd_o.issue = 1'b1;
        unique case (pt_q)
          3'd0:    cmd_o.tag = 1'b1;
          3'd1:    cmd_o.off_x = OFF_W'(ONE_Q12);
          3'd2:    cmd_o.off_x = -OFF_W'(ONE_Q12);
          3'd3:    cmd_o.off_y = OFF_W'(ONE_Q12);
          3'd4:    cmd_o.off_y = -OFF_W'(ONE_Q12);
          3'd5:    cmd_o.off_z = OFF_W'(ONE_Q12);
          3'd6:    cmd_o.off_z = -OFF_W'(ONE_Q12);
          default: ;
        endcase
      end
      ST_NDRAIN: cmd_o.clear = !status_i.busy && (decide == KIND_PARTIAL);
      ST_GRID: begin
        cmd_o.issue = 1'b1;
        cmd_o.off_x = ga_q.off;
        cmd_o.off_y = gb_q.off;
        cmd_o.off_z = ge_q.off;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // point and grid counters, innermost axis is z
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) pt_q <= 3'd0;
    else if (state_q == ST_NEIGH) pt_q <= pt_q + 3'd1;
    if (state_q != ST_GRID) begin
      ia_q <= '0; ib_q <= '0; ie_q <= '0;
      ga_q <= GRID0; gb_q <= GRID0; ge_q <= GRID0;
    end else if (ie_q != GIDX_W'(SUBSTEPS)) begin
      ie_q <= ie_q + GIDX_W'(1);
      ge_q <= grid_step(ge_q);
    end else begin
      ie_q <= '0;
      ge_q <= GRID0;
      if (ib_q != GIDX_W'(SUBSTEPS)) begin
        ib_q <= ib_q + GIDX_W'(1);
        gb_q <= grid_step(gb_q);
      end else begin
        ib_q <= '0;
        gb_q <= GRID0;
        ia_q <= ia_q + GIDX_W'(1);
        ga_q <= grid_step(ga_q);
      end
    end
    if (state_q == ST_NDRAIN) res_q <= decide;
  end

  // result register, parts the output side from the work
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      kind_q <= res_q;
      samp_q <= (res_q == KIND_PARTIAL) ? status_i.count[SAMPLES_W-1:0] : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign voxel_kind_o     = kind_q;
  assign inside_samples_o = samp_q;
endmodule

// File: hdl/ellipsoid_voxel_partial_volume.sv
// Top level of the ellipsoid partial-volume voxel classifier.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o | voxel_x_i, voxel_y_i, voxel_z_i
//   out     | output    | out_valid_o/out_stall_i | voxel_kind_o, inside_samples_o
//   cfg     | input     | cfg_we_i              | cfg_index_i, cfg_data_i
//
// One point is issued per cycle into a 7-stage pipeline (three axis lanes).
// Interior or outside voxel: 7 points are issued, then the pipeline drains.
// Boundary voxel in partial mode: (SUBSTEPS+1)^3 grid points follow, then a second drain.
// Reset clears the sequencer and loads the register defaults; no clearing pass.
// A stalled result waits in its output register; the next voxel is taken meanwhile.
module ellipsoid_voxel_partial_volume
  import evpv_pkg::*;
#(
  parameter int unsigned SUBSTEPS   = SUBSTEPS_DEF,
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [INDEX_BITS-1:0] voxel_x_i,
  input  logic [INDEX_BITS-1:0] voxel_y_i,
  input  logic [INDEX_BITS-1:0] voxel_z_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KIND_W-1:0]     voxel_kind_o,
  output logic [SAMPLES_W-1:0]  inside_samples_o
);
  dp_cmd_t    cmd;
  dp_status_t status;

  evpv_ctrl #(.SUBSTEPS(SUBSTEPS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .voxel_kind_o, .inside_samples_o, .status_i(status), .cmd_o(cmd));

  evpv_datapath #(.INDEX_BITS(INDEX_BITS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .voxel_x_i, .voxel_y_i, .voxel_z_i, .cmd_i(cmd), .status_o(status));
endmodule

// File: hdl/evpv_checker.sv
// Port-level checker for the voxel classifier, bound to the top level.
`include "ellipsoid_voxel_partial_volume_assert.svh"
module evpv_checker
  import evpv_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [KIND_W-1:0]    voxel_kind_o,
  input logic [SAMPLES_W-1:0] inside_samples_o
);
  `EVPV_ASSERT_NOW(a_kind_legal, out_valid_o, voxel_kind_o != 2'd3)
  `EVPV_ASSERT_NOW(a_samples_zero, out_valid_o && (voxel_kind_o != KIND_PARTIAL), inside_samples_o == '0)
  `EVPV_ASSERT_NEXT(a_busy_after_in, in_valid_i && !in_stall_o, in_stall_o)
  `EVPV_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(voxel_kind_o) && $stable(inside_samples_o))
endmodule

bind ellipsoid_voxel_partial_volume evpv_checker u_evpv_checker (.*);
